FILE: rtl/metric_record_frame_parser_top_assert.svh
// Assertion macros for the record framer checker.
`ifndef METRIC_RECORD_FRAME_PARSER_TOP_ASSERT_SVH
`define METRIC_RECORD_FRAME_PARSER_TOP_ASSERT_SVH

// Check a property on the rising clock edge, skipped while reset is held.
`define MRFP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check a property on the rising clock edge, reset included.
`define MRFP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/mrfp_pkg.sv
`default_nettype none

package mrfp_pkg;

    localparam logic [7:0] MAGIC_BYTE   = 8'hAA;
    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

    localparam logic [7:0] TYPE_KEY_VALUE  = 8'h01;
    localparam logic [7:0] TYPE_COUNTER    = 8'h02;
    localparam logic [7:0] TYPE_TIMER      = 8'h03;
    localparam logic [7:0] TYPE_SET        = 8'h04;
    localparam logic [7:0] TYPE_GAUGE      = 8'h05;
    localparam logic [7:0] TYPE_GAUGE_DELTA = 8'h06;

    localparam logic [3:0] HDR_FIRST      = 4'd2;
    localparam logic [3:0] HDR_NAME_HI    = 4'd3;
    localparam logic [3:0] HDR_MEMBER_LO  = 4'd4;
    localparam logic [3:0] HDR_VALUE_BASE = 4'd4;
    localparam logic [3:0] METRIC_HDR_END = 4'd12;
    localparam logic [3:0] SET_HDR_END    = 4'd6;

    typedef enum logic [2:0] {
        KIND_KEY_VALUE  = 3'd0,
        KIND_COUNTER    = 3'd1,
        KIND_TIMER      = 3'd2,
        KIND_GAUGE      = 3'd3,
        KIND_GAUGE_DELTA = 3'd4,
        KIND_SET        = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        EV_METRIC_BYTE = 3'd0,
        EV_SET_NAME    = 3'd1,
        EV_SET_MEMBER  = 3'd2,
        EV_METRIC_DONE = 3'd3,
        EV_SET_DONE    = 3'd4,
        EV_ERROR       = 3'd5
    } t_event;

    typedef enum logic [1:0] {
        ERR_MAGIC  = 2'd0,
        ERR_TYPE   = 2'd1,
        ERR_NAME   = 2'd2,
        ERR_MEMBER = 2'd3
    } t_err;

    typedef struct packed {
        logic       fire;
        logic [7:0] data;
    } t_step;

    typedef struct packed {
        t_event      event_res;
        logic [7:0]  byte_out;
        logic [2:0]  metric_kind;
        logic [63:0] value_bits;
        t_err        error_code;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_res_pkt;

endpackage

`default_nettype wire

FILE: rtl/mrfp_if.sv
`default_nettype none

interface mrfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink (input valid, input stream_byte, output ready);
endinterface

interface mrfp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [7:0]  byte_out;
    logic [2:0]  metric_kind;
    logic [63:0] value_bits;
    logic [1:0]  error_code;

    modport source (
        output valid, output event_res, output byte_out, output metric_kind,
        output value_bits, output error_code, input ready
    );
    modport sink (
        input valid, input event_res, input byte_out, input metric_kind,
        input value_bits, input error_code, output ready
    );
endinterface

`default_nettype wire

FILE: rtl/mrfp_in_reg.sv
`default_nettype none

module mrfp_in_reg
    import mrfp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire logic [7:0] i_data,
    input  wire logic  i_advance,
    output logic       o_ready,
    output t_step      o_step
);

    logic       r_valid;
    logic [7:0] r_data;

    assign o_ready     = !r_valid || i_advance;
    assign o_step.fire = r_valid && i_advance;
    assign o_step.data = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/mrfp_core.sv
`default_nettype none

module mrfp_core
    import mrfp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_step i_step,
    output t_res_pkt   o_pkt
);

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_TYPE,
        PH_HEADER,
        PH_NAME,
        PH_MEMBER
    } t_phase;

    t_phase      r_phase,   n_phase;
    logic [3:0]  r_hdr_idx, n_hdr_idx;
    t_kind       r_kind,    n_kind;
    logic [15:0] r_name_len, n_name_len;
    logic [15:0] r_member_len, n_member_len;
    logic [63:0] r_value,   n_value;
    logic [15:0] r_left,    n_left;
    logic        r_nl_skip, n_nl_skip;
    logic        r_halted,  n_halted;

    logic        n_res_valid;
    t_result     n_res;
    logic [7:0]  b;
    logic [2:0]  val_slot;

    assign b        = i_step.data;
    assign val_slot = 3'(r_hdr_idx - HDR_VALUE_BASE);

    always_comb begin
        n_phase      = r_phase;
        n_hdr_idx    = r_hdr_idx;
        n_kind       = r_kind;
        n_name_len   = r_name_len;
        n_member_len = r_member_len;
        n_value      = r_value;
        n_left       = r_left;
        n_nl_skip    = r_nl_skip;
        n_halted     = r_halted;
        n_res_valid  = 1'b0;
        n_res        = '0;

        if (!r_halted) begin
            case (r_phase)
                PH_WAIT: begin
                    if (b == NEWLINE_BYTE && !r_nl_skip) begin
                        n_nl_skip = 1'b1;
                    end else if (b != MAGIC_BYTE) begin
                        n_halted         = 1'b1;
                        n_res_valid      = 1'b1;
                        n_res.event_res  = EV_ERROR;
                        n_res.error_code = ERR_MAGIC;
                    end else begin
                        n_nl_skip = 1'b0;
                        n_phase   = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    n_hdr_idx    = HDR_FIRST;
                    n_name_len   = '0;
                    n_member_len = '0;
                    n_value      = '0;
                    n_phase      = PH_HEADER;
                    case (b)
                        TYPE_KEY_VALUE:   n_kind = KIND_KEY_VALUE;
                        TYPE_COUNTER:     n_kind = KIND_COUNTER;
                        TYPE_TIMER:       n_kind = KIND_TIMER;
                        TYPE_GAUGE:       n_kind = KIND_GAUGE;
                        TYPE_GAUGE_DELTA: n_kind = KIND_GAUGE_DELTA;
                        TYPE_SET:         n_kind = KIND_SET;
                        default: begin
                            n_hdr_idx        = r_hdr_idx;
                            n_name_len       = r_name_len;
                            n_member_len     = r_member_len;
                            n_value          = r_value;
                            n_phase          = r_phase;
                            n_halted         = 1'b1;
                            n_res_valid      = 1'b1;
                            n_res.event_res  = EV_ERROR;
                            n_res.error_code = ERR_TYPE;
                        end
                    endcase
                end
                PH_HEADER: begin
                    n_hdr_idx = r_hdr_idx + 4'd1;
                    if (r_hdr_idx == HDR_FIRST) begin
                        n_name_len = {8'h00, b};
                    end else if (r_hdr_idx == HDR_NAME_HI) begin
                        n_name_len = {b, r_name_len[7:0]};
                        if (n_name_len == '0) begin
                            n_halted         = 1'b1;
                            n_res_valid      = 1'b1;
                            n_res.event_res  = EV_ERROR;
                            n_res.error_code = ERR_NAME;
                        end
                    end else if (r_kind == KIND_SET) begin
                        if (r_hdr_idx == HDR_MEMBER_LO) begin
                            n_member_len = {8'h00, b};
                        end else begin
                            n_member_len = {b, r_member_len[7:0]};
                            if (n_member_len == '0) begin
                                n_halted         = 1'b1;
                                n_res_valid      = 1'b1;
                                n_res.event_res  = EV_ERROR;
                                n_res.error_code = ERR_MEMBER;
                            end else begin
                                n_left  = r_name_len;
                                n_phase = PH_NAME;
                            end
                        end
                    end else begin
                        n_value[{val_slot, 3'b000} +: 8] = b;
                        if (n_hdr_idx == METRIC_HDR_END) begin
                            n_left  = r_name_len;
                            n_phase = PH_NAME;
                        end
                    end
                end
                PH_NAME: begin
                    n_left = r_left - 16'd1;
                    if (n_left != '0) begin
                        n_res_valid     = 1'b1;
                        n_res.event_res = (r_kind == KIND_SET) ? EV_SET_NAME
                                                               : EV_METRIC_BYTE;
                        n_res.byte_out  = b;
                    end else if (b != 8'h00) begin
                        n_halted         = 1'b1;
                        n_res_valid      = 1'b1;
                        n_res.event_res  = EV_ERROR;
                        n_res.error_code = ERR_NAME;
                    end else if (r_kind == KIND_SET) begin
                        n_left  = r_member_len;
                        n_phase = PH_MEMBER;
                    end else begin
                        n_phase           = PH_WAIT;
                        n_res_valid       = 1'b1;
                        n_res.event_res   = EV_METRIC_DONE;
                        n_res.metric_kind = r_kind;
                        n_res.value_bits  = r_value;
                    end
                end
                PH_MEMBER: begin
                    n_left = r_left - 16'd1;
                    if (n_left != '0) begin
                        n_res_valid     = 1'b1;
                        n_res.event_res = EV_SET_MEMBER;
                        n_res.byte_out  = b;
                    end else if (b != 8'h00) begin
                        n_halted         = 1'b1;
                        n_res_valid      = 1'b1;
                        n_res.event_res  = EV_ERROR;
                        n_res.error_code = ERR_MEMBER;
                    end else begin
                        n_phase         = PH_WAIT;
                        n_res_valid     = 1'b1;
                        n_res.event_res = EV_SET_DONE;
                    end
                end
                default: begin
                    n_halted = 1'b1;
                end
            endcase
        end
    end

    assign o_pkt.valid = i_step.fire && n_res_valid;
    assign o_pkt.res   = n_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_WAIT;
            r_hdr_idx    <= '0;
            r_kind       <= KIND_KEY_VALUE;
            r_name_len   <= '0;
            r_member_len <= '0;
            r_value      <= '0;
            r_left       <= '0;
            r_nl_skip    <= 1'b0;
            r_halted     <= 1'b0;
        end else if (i_step.fire) begin
            r_phase      <= n_phase;
            r_hdr_idx    <= n_hdr_idx;
            r_kind       <= n_kind;
            r_name_len   <= n_name_len;
            r_member_len <= n_member_len;
            r_value      <= n_value;
            r_left       <= n_left;
            r_nl_skip    <= n_nl_skip;
            r_halted     <= n_halted;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/mrfp_out_reg.sv
`default_nettype none

module mrfp_out_reg
    import mrfp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_res_pkt i_pkt,
    input  wire logic     i_ready,
    output logic          o_advance,
    output logic          o_valid,
    output t_result       o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_advance = !r_valid || i_ready;
    assign o_valid   = r_valid;
    assign o_res     = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_pkt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_pkt.valid) begin
            r_res <= i_pkt.res;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/metric_record_frame_parser_top.sv
// Channel   Dir  Payload                                              Type
// i_in      in   stream_byte                                          mrfp_in_if.sink
// o_out     out  event_res byte_out metric_kind value_bits error_code mrfp_out_if.source
//
// One byte a cycle while the output does not stall; each result leaves from the result register.
// Input register, state update, result register; one stall signal spans all three.
// While a result waits, the input takes one more item into its register and then stalls.
// Reset is synchronous, active low; after an error nothing comes out until reset.
`default_nettype none

module metric_record_frame_parser_top
    import mrfp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mrfp_in_if.sink    i_in,
    mrfp_out_if.source o_out
);

    logic     advance;
    t_step    step;
    t_res_pkt pkt;
    t_result  res;

    mrfp_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .i_data    (i_in.stream_byte),
        .i_advance (advance),
        .o_ready   (i_in.ready),
        .o_step    (step)
    );

    mrfp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .o_pkt   (pkt)
    );

    mrfp_out_reg u_out_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pkt     (pkt),
        .i_ready   (o_out.ready),
        .o_advance (advance),
        .o_valid   (o_out.valid),
        .o_res     (res)
    );

    assign o_out.event_res   = res.event_res;
    assign o_out.byte_out    = res.byte_out;
    assign o_out.metric_kind = res.metric_kind;
    assign o_out.value_bits  = res.value_bits;
    assign o_out.error_code  = res.error_code;

endmodule

`default_nettype wire

FILE: rtl/mrfp_checker.sv
`default_nettype none
`include "metric_record_frame_parser_top_assert.svh"

module mrfp_checker
    import mrfp_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [2:0]  i_event_res,
    input wire logic [7:0]  i_byte_out,
    input wire logic [2:0]  i_metric_kind,
    input wire logic [63:0] i_value_bits,
    input wire logic [1:0]  i_error_code
);

    logic r_err_seen;
    logic in_fire;

    assign in_fire = i_in_valid && i_in_ready;

    // Hold a flag once an error item has been taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_seen <= 1'b0;
        end else if (i_out_valid && i_out_ready && i_event_res == EV_ERROR) begin
            r_err_seen <= 1'b1;
        end
    end

    `MRFP_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_event_res) && $stable(i_byte_out) && $stable(i_value_bits) && $stable(i_error_code), "result changed while stalled")
    `MRFP_ASSERT(a_silent_after_error, i_clk, i_rst_n, r_err_seen |-> !i_out_valid, "result after error")
    `MRFP_ASSERT(a_byte_only_on_byte_event, i_clk, i_rst_n, i_out_valid && (i_event_res == EV_METRIC_DONE || i_event_res == EV_SET_DONE || i_event_res == EV_ERROR) |-> i_byte_out == 8'h00, "byte on non-byte event")
    `MRFP_ASSERT(a_value_only_on_metric_done, i_clk, i_rst_n, i_out_valid && i_event_res != EV_METRIC_DONE |-> i_value_bits == 64'h0 && i_metric_kind == 3'd0, "value on wrong event")
    `MRFP_ASSERT_ALWAYS(a_no_ready_stuck_with_empty_out, i_clk, !i_out_valid && i_rst_n && $past(i_rst_n) && !in_fire |-> i_in_ready, "input stalled with empty output")

endmodule

bind metric_record_frame_parser_top mrfp_checker u_mrfp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_event_res   (o_out.event_res),
    .i_byte_out    (o_out.byte_out),
    .i_metric_kind (o_out.metric_kind),
    .i_value_bits  (o_out.value_bits),
    .i_error_code  (o_out.error_code)
);

`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import mrfp_pkg::*;

    localparam int ITEM_TARGET    = 900;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int MAX_PRINTED    = 50;

    typedef enum logic [2:0] {
        SCAN_MAGIC,
        SCAN_TYPE,
        SCAN_HEADER,
        SCAN_NAME,
        SCAN_MEMBER
    } t_scan;

    typedef enum logic [1:0] {
        BREAK_NONE,
        BREAK_NAME,
        BREAK_MEMBER
    } t_break;

    typedef enum logic [2:0] {
        FAULT_MAGIC,
        FAULT_NEWLINE,
        FAULT_TYPE,
        FAULT_NAME_LEN,
        FAULT_MEMBER_LEN,
        FAULT_NAME_TERM,
        FAULT_SET_NAME_TERM,
        FAULT_MEMBER_TERM
    } t_fault;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mrfp_in_if  in_if ();
    mrfp_out_if out_if ();

    metric_record_frame_parser_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #1 i_clk = ~i_clk;

    t_scan       scan_phase    = SCAN_MAGIC;
    logic [3:0]  hdr_index     = '0;
    t_kind       rec_kind      = KIND_KEY_VALUE;
    logic [15:0] name_len_acc  = '0;
    logic [15:0] member_len_acc = '0;
    logic [63:0] value_acc     = '0;
    logic [16:0] bytes_left    = '0;
    logic        newline_seen  = 1'b0;
    logic        parse_halted  = 1'b0;

    t_result pending_events[$];
    int      mismatches = 0;
    int      items_sent = 0;
    int      quiet_cycles = 0;
    bit      idle_on = 1'b1;

    function automatic bit raise_fault(input t_err code, output t_result r);
        r = '0;
        r.event_res  = EV_ERROR;
        r.error_code = code;
        parse_halted = 1'b1;
        return 1'b1;
    endfunction

    function automatic bit parse_byte(input logic [7:0] b, output t_result r);
        logic [3:0] idx;
        r = '0;
        if (parse_halted) return 1'b0;
        case (scan_phase)
            SCAN_MAGIC: begin
                if (b == NEWLINE_BYTE && !newline_seen) begin
                    newline_seen = 1'b1;
                    return 1'b0;
                end
                if (b != MAGIC_BYTE) return raise_fault(ERR_MAGIC, r);
                newline_seen = 1'b0;
                scan_phase = SCAN_TYPE;
                return 1'b0;
            end
            SCAN_TYPE: begin
                case (b)
                    TYPE_KEY_VALUE:   rec_kind = KIND_KEY_VALUE;
                    TYPE_COUNTER:     rec_kind = KIND_COUNTER;
                    TYPE_TIMER:       rec_kind = KIND_TIMER;
                    TYPE_GAUGE:       rec_kind = KIND_GAUGE;
                    TYPE_GAUGE_DELTA: rec_kind = KIND_GAUGE_DELTA;
                    TYPE_SET:         rec_kind = KIND_SET;
                    default:          return raise_fault(ERR_TYPE, r);
                endcase
                hdr_index = HDR_FIRST;
                name_len_acc = '0;
                member_len_acc = '0;
                value_acc = '0;
                scan_phase = SCAN_HEADER;
                return 1'b0;
            end
            SCAN_HEADER: begin
                idx = hdr_index;
                hdr_index = idx + 4'd1;
                if (idx == HDR_FIRST) begin
                    name_len_acc = {8'h00, b};
                    return 1'b0;
                end
                if (idx == HDR_NAME_HI) begin
                    name_len_acc[15:8] = b;
                    if (name_len_acc == 16'd0) return raise_fault(ERR_NAME, r);
                    return 1'b0;
                end
                if (rec_kind == KIND_SET) begin
                    if (idx == HDR_MEMBER_LO) begin
                        member_len_acc = {8'h00, b};
                        return 1'b0;
                    end
                    member_len_acc[15:8] = b;
                    if (member_len_acc == 16'd0) return raise_fault(ERR_MEMBER, r);
                    bytes_left = {1'b0, name_len_acc};
                    scan_phase = SCAN_NAME;
                    return 1'b0;
                end
                value_acc[8 * int'(idx - HDR_VALUE_BASE) +: 8] = b;
                if (idx == METRIC_HDR_END - 4'd1) begin
                    bytes_left = {1'b0, name_len_acc};
                    scan_phase = SCAN_NAME;
                end
                return 1'b0;
            end
            SCAN_NAME: begin
                bytes_left = bytes_left - 17'd1;
                if (bytes_left != 17'd0) begin
                    r.event_res = (rec_kind == KIND_SET) ? EV_SET_NAME : EV_METRIC_BYTE;
                    r.byte_out = b;
                    return 1'b1;
                end
                if (b != 8'h00) return raise_fault(ERR_NAME, r);
                if (rec_kind == KIND_SET) begin
                    bytes_left = {1'b0, member_len_acc};
                    scan_phase = SCAN_MEMBER;
                    return 1'b0;
                end
                scan_phase = SCAN_MAGIC;
                r.event_res = EV_METRIC_DONE;
                r.metric_kind = rec_kind;
                r.value_bits = value_acc;
                return 1'b1;
            end
            SCAN_MEMBER: begin
                bytes_left = bytes_left - 17'd1;
                if (bytes_left != 17'd0) begin
                    r.event_res = EV_SET_MEMBER;
                    r.byte_out = b;
                    return 1'b1;
                end
                if (b != 8'h00) return raise_fault(ERR_MEMBER, r);
                scan_phase = SCAN_MAGIC;
                r.event_res = EV_SET_DONE;
                return 1'b1;
            end
            default: begin
                parse_halted = 1'b1;
                return 1'b0;
            end
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        if (mismatches < MAX_PRINTED)
            $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        int      gap;
        t_result r;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.stream_byte <= b;
        do @(posedge i_clk); while (!in_if.ready);
        if (parse_byte(b, r)) pending_events.push_back(r);
        items_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] type_code(input int unsigned sel);
        case (sel)
            0:       return TYPE_KEY_VALUE;
            1:       return TYPE_COUNTER;
            2:       return TYPE_TIMER;
            3:       return TYPE_GAUGE;
            4:       return TYPE_GAUGE_DELTA;
            default: return TYPE_SET;
        endcase
    endfunction

    function automatic logic [7:0] content_byte();
        return ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
    endfunction

    task automatic send_record(input logic [7:0] code, input bit lead_nl,
                               input logic [15:0] name_len, input logic [15:0] member_len,
                               input logic [63:0] value, input t_break brk);
        if (lead_nl) send_byte(NEWLINE_BYTE);
        send_byte(MAGIC_BYTE);
        send_byte(code);
        send_byte(name_len[7:0]);
        send_byte(name_len[15:8]);
        if (code == TYPE_SET) begin
            send_byte(member_len[7:0]);
            send_byte(member_len[15:8]);
        end else begin
            for (int i = 0; i < 8; i++) send_byte(value[8 * i +: 8]);
        end
        if (name_len != 0) begin
            for (int i = 1; i < int'(name_len); i++) send_byte(content_byte());
            send_byte(brk == BREAK_NAME ? 8'($urandom_range(1, 255)) : 8'h00);
        end
        if (code == TYPE_SET && member_len != 0) begin
            for (int i = 1; i < int'(member_len); i++) send_byte(content_byte());
            send_byte(brk == BREAK_MEMBER ? 8'($urandom_range(1, 255)) : 8'h00);
        end
    endtask

    function automatic logic [63:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [15:0] pick_length();
        return ($urandom_range(0, 9) == 0) ? 16'($urandom_range(9, 300))
                                           : 16'($urandom_range(1, 8));
    endfunction

    task automatic test_record_types();
        for (int unsigned i = 0; i < 6; i++)
            send_record(type_code(i), i == 0, 16'(i + 1), 16'(i % 3 + 1),
                        (i % 2) ? '1 : 64'h8000_0000_0000_0001, BREAK_NONE);
        send_record(TYPE_SET, 1'b1, 16'd1, 16'd1, '0, BREAK_NONE);
    endtask

    task automatic test_longest_name();
        idle_on = 1'b0;
        send_record(TYPE_COUNTER, 1'b0, 16'h0101, '0, pick_value(), BREAK_NONE);
        send_record(TYPE_SET, 1'b0, 16'h0003, 16'h0101, '0, BREAK_NONE);
        idle_on = 1'b1;
    endtask

    task automatic test_random_records();
        while (items_sent < ITEM_TARGET) begin
            idle_on = ($urandom_range(0, 4) != 0);
            send_record(type_code($urandom_range(0, 5)), $urandom_range(0, 3) == 0,
                        pick_length(), pick_length(), pick_value(), BREAK_NONE);
        end
        idle_on = 1'b1;
    endtask

    task automatic test_fault_then_drop();
        t_fault     fault;
        logic [7:0] b;
        fault = t_fault'($urandom_range(0, 7));
        case (fault)
            FAULT_MAGIC: begin
                do b = 8'($urandom_range(0, 255));
                while (b == MAGIC_BYTE || b == NEWLINE_BYTE);
                send_byte(b);
            end
            FAULT_NEWLINE: begin
                send_byte(NEWLINE_BYTE);
                send_byte(NEWLINE_BYTE);
            end
            FAULT_TYPE: begin
                do b = 8'($urandom_range(0, 255));
                while (b >= TYPE_KEY_VALUE && b <= TYPE_GAUGE_DELTA);
                send_byte(MAGIC_BYTE);
                send_byte(b);
            end
            FAULT_NAME_LEN:
                send_record(type_code($urandom_range(0, 5)), $urandom_range(0, 1),
                            '0, pick_length(), pick_value(), BREAK_NONE);
            FAULT_MEMBER_LEN:
                send_record(TYPE_SET, $urandom_range(0, 1), pick_length(), '0, '0,
                            BREAK_NONE);
            FAULT_NAME_TERM:
                send_record(type_code($urandom_range(0, 4)), $urandom_range(0, 1),
                            pick_length(), '0, pick_value(), BREAK_NAME);
            FAULT_SET_NAME_TERM:
                send_record(TYPE_SET, $urandom_range(0, 1), pick_length(), pick_length(),
                            '0, BREAK_NAME);
            default:
                send_record(TYPE_SET, $urandom_range(0, 1), pick_length(), pick_length(),
                            '0, BREAK_MEMBER);
        endcase
        repeat (40) send_byte(8'($urandom_range(0, 255)));
        send_record(TYPE_GAUGE, 1'b0, 16'd3, '0, pick_value(), BREAK_NONE);
    endtask

    initial begin
        int         stall;
        out_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = idle_on ? $urandom_range(0, 6) : 0;
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_events.size() == 0) begin
                flag_mismatch("unexpected result", 64'(out_if.event_res), '0);
            end else begin
                want = pending_events.pop_front();
                if (out_if.event_res !== want.event_res)
                    flag_mismatch("event_res", 64'(out_if.event_res), 64'(want.event_res));
                if (out_if.byte_out !== want.byte_out)
                    flag_mismatch("byte_out", 64'(out_if.byte_out), 64'(want.byte_out));
                if (out_if.metric_kind !== want.metric_kind)
                    flag_mismatch("metric_kind", 64'(out_if.metric_kind),
                                  64'(want.metric_kind));
                if (out_if.value_bits !== want.value_bits)
                    flag_mismatch("value_bits", out_if.value_bits, want.value_bits);
                if (out_if.error_code !== want.error_code)
                    flag_mismatch("error_code", 64'(out_if.error_code),
                                  64'(want.error_code));
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no item accepted for %0d cycles", WATCHDOG_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.stream_byte = 8'h00;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_record_types();
        test_longest_name();
        test_random_records();
        test_fault_then_drop();
        in_if.valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        while (pending_events.size() != 0) begin
            flag_mismatch("missing result", '0, 64'(pending_events[0].event_res));
            void'(pending_events.pop_front());
        end
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: metric_record_frame_parser_top.f
+incdir+rtl
rtl/mrfp_pkg.sv
rtl/mrfp_if.sv
rtl/mrfp_in_reg.sv
rtl/mrfp_core.sv
rtl/mrfp_out_reg.sv
rtl/metric_record_frame_parser_top.sv
rtl/mrfp_checker.sv
verif/testbench.sv
